/* rtl/uvd_pkg.sv */
// shared types, codes and widths for the unique value deque
// no dependencies; imported by uvd_cell, unique_value_deque_top and the testbench
package uvd_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 5;
  localparam int OUT_TDATA_W  = 80;

  // operation codes carried on s_tuser
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REMOVE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;
  localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd6;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd3;

  // per-cycle command broadcast to every cell of the row
  typedef struct packed {
    logic cmp;       // latch compare of each cell against the incoming value
    logic shr;       // take left neighbor (push front)
    logic shl;       // take right neighbor (pop front)
    logic shl_seen;  // take right neighbor at and behind the matching cell
    logic load_end;  // cell at the fill level takes the operand (push back)
  } cell_ctl_t;

endpackage

/* rtl/uvd_cell.sv */
// one storage cell of the deque row: value, match flag, neighbor shifts
// depends on uvd_pkg
module uvd_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  logic                           clk,
  input  uvd_pkg::cell_ctl_t             ctl,
  input  logic [uvd_pkg::VALUE_W-1:0]    cmp_value,
  input  logic [uvd_pkg::VALUE_W-1:0]    op_value,
  input  logic [uvd_pkg::VALUE_W-1:0]    left_data,
  input  logic [uvd_pkg::VALUE_W-1:0]    right_data,
  input  logic [OCC_W-1:0]               occ,
  input  logic                           seen_in,
  output logic [uvd_pkg::VALUE_W-1:0]    data,
  output logic                           match,
  output logic                           seen_out
);
  import uvd_pkg::*;

  logic active;
  logic at_end;

  assign active   = occ > OCC_W'(IDX);
  assign at_end   = occ == OCC_W'(IDX);
  // this cell or one in front of it holds the removed value
  assign seen_out = seen_in | match;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= active && (data == cmp_value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shr) begin
      data <= left_data;
    end else if (ctl.shl || (ctl.shl_seen && seen_out)) begin
      data <= right_data;
    end else if (ctl.load_end && at_end) begin
      data <= op_value;
    end
  end

endmodule

/* rtl/unique_value_deque_top.sv */
// unique value deque: row of cells with shared control and result register
// depends on uvd_pkg and uvd_cell
//
// channel  | dir | handshake          | payload
// s        | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata value
// m        | out | m_tvalid/m_tready  | m_tdata status, front, back, count, flags
//
// an item takes three steps: accept (every cell latches its compare), execute (at
// most one shift or load across the row and the fill level update), result (front and
// back read out into the output register). the next item is taken after that load.
// rst clears the fill level, the control state and the output valid; cell contents
// stay undefined. a stalled m side holds the item in its result step.
module unique_value_deque_top #(
  parameter int CAPACITY = uvd_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [uvd_pkg::VALUE_W-1:0]        s_tdata,  // [31:0] value
  input  logic [uvd_pkg::MODE_W-1:0]         s_tuser,  // [2:0] mode
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [33:2] front_value, [65:34] back_value, [70:66] count,
  // [71] is_empty, [72] was_present, [79:73] zero
  output logic [uvd_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import uvd_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);
  localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);
  localparam int PAD_W = OUT_TDATA_W - (STATUS_W + 2 * VALUE_W + COUNT_W + 2);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [OCC_W-1:0]    occ;
  logic [OCC_W-1:0]    occ_next;
  logic [MODE_W-1:0]   mode;
  logic [VALUE_W-1:0]  val;
  logic [STATUS_W-1:0] status;
  logic [STATUS_W-1:0] status_next;
  logic                present;
  logic                present_any;
  cell_ctl_t           ctl;

  logic [VALUE_W-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0] match_v;
  logic [CAPACITY:0]   seen;

  logic [VALUE_W-1:0]  front_sel;
  logic [VALUE_W-1:0]  back_sel;
  logic                out_load;

  assign s_tready    = state == S_IDLE;
  assign present_any = |match_v;
  assign out_load    = (state == S_DONE) && (!m_tvalid || m_tready);
  assign seen[0]     = 1'b0;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VALUE_W-1:0] left_d;
      logic [VALUE_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = val;
      end else begin : g_mid
        assign left_d = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_d = cell_data[g];
      end else begin : g_inner
        assign right_d = cell_data[g+1];
      end
      uvd_cell #(
        .IDX   (g),
        .OCC_W (OCC_W)
      ) u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .cmp_value  (s_tdata),
        .op_value   (val),
        .left_data  (left_d),
        .right_data (right_d),
        .occ        (occ),
        .seen_in    (seen[g]),
        .data       (cell_data[g]),
        .match      (match_v[g]),
        .seen_out   (seen[g+1])
      );
    end
  endgenerate

  // decide the operation once the compares are in
  always_comb begin
    ctl         = '0;
    ctl.cmp     = s_tvalid && s_tready;
    status_next = ST_DONE;
    occ_next    = occ;
    state_next  = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (mode)
          MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (present_any) begin
              status_next = ST_DUP;
            end else if (occ == OCC_FULL) begin
              status_next = ST_FULL;
            end else begin
              if (mode == MODE_PUSH_FRONT) begin
                ctl.shr = 1'b1;
              end else begin
                ctl.load_end = 1'b1;
              end
              occ_next = occ + OCC_ONE;
            end
          end
          MODE_POP_FRONT: begin
            if (occ == '0) begin
              status_next = ST_MISS;
            end else begin
              ctl.shl  = 1'b1;
              occ_next = occ - OCC_ONE;
            end
          end
          MODE_POP_BACK: begin
            if (occ == '0) begin
              status_next = ST_MISS;
            end else begin
              occ_next = occ - OCC_ONE;
            end
          end
          MODE_REMOVE: begin
            if (!present_any) begin
              status_next = ST_MISS;
            end else begin
              ctl.shl_seen = 1'b1;
              occ_next     = occ - OCC_ONE;
            end
          end
          MODE_CLEAR: begin
            occ_next = '0;
          end
          MODE_QUERY: begin
          end
          default: begin
          end
        endcase
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        occ <= occ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      mode <= s_tuser;
      val  <= s_tdata;
    end
    if (state == S_EXEC) begin
      status  <= status_next;
      present <= present_any;
    end
  end

  // back is the cell just below the fill level
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      back_sel = back_sel | (cell_data[i] & {VALUE_W{occ == OCC_W'(i + 1)}});
    end
    front_sel = (occ != '0) ? cell_data[0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, present, (occ == '0), COUNT_W'(occ),
                  back_sel, front_sel, status};
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= OCC_FULL)
    else $error("fill level above capacity");

  a_unique: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(match_v))
    else $error("value stored in more than one cell");

  a_dup_present: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[1:0] == ST_DUP)) |-> m_tdata[72])
    else $error("duplicate refusal without presence");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[71]) |-> ((m_tdata[65:2] == '0) && (m_tdata[70:66] == '0)))
    else $error("empty result with nonzero front, back or count");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (state != S_EXEC) |=> $stable(occ) || $past(rst))
    else $error("fill level changed outside execute");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// self-checking bench for unique_value_deque_top: directed table, then random phases
// depends on uvd_pkg and the deque rtl; keeps its own queue-based copy of the deque

module testbench;
  import uvd_pkg::*;

  localparam int CAPACITY = CAPACITY_DEF;
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;  // unused code, acts as a query
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 80;

  // same bit order as m_tdata[72:0], status lowest
  typedef struct packed {
    logic                was_present;
    logic                is_empty;
    logic [COUNT_W-1:0]  count;
    logic [VALUE_W-1:0]  back_value;
    logic [VALUE_W-1:0]  front_value;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    int                 reps;
    bit                 typed;
    deque_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [VALUE_W-1:0] s_tdata = '0;
  logic [MODE_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [VALUE_W-1:0] stored[$];       // deque contents, front at index 0
  deque_result_t results_due[$];
  stim_row_t directed_rows[$];
  int errors = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  unique_value_deque_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic deque_result_t deque_apply(input logic [MODE_W-1:0] mode,
                                                input logic [VALUE_W-1:0] value);
    deque_result_t r;
    int slot;
    slot = -1;
    foreach (stored[i])
      if (stored[i] == value) slot = i;
    r.status = ST_DONE;
    r.was_present = (slot >= 0);
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        // duplicate wins over full
        if (slot >= 0) r.status = ST_DUP;
        else if (stored.size() >= CAPACITY) r.status = ST_FULL;
        else if (mode == MODE_PUSH_FRONT) stored.push_front(value);
        else stored.push_back(value);
      end
      MODE_POP_FRONT: begin
        if (stored.size() == 0) r.status = ST_MISS;
        else void'(stored.pop_front());
      end
      MODE_POP_BACK: begin
        if (stored.size() == 0) r.status = ST_MISS;
        else void'(stored.pop_back());
      end
      MODE_REMOVE: begin
        if (slot < 0) r.status = ST_MISS;
        else stored.delete(slot);
      end
      MODE_CLEAR: stored.delete();
      default: ;
    endcase
    r.front_value = stored.size() ? stored[0] : '0;
    r.back_value = stored.size() ? stored[stored.size() - 1] : '0;
    r.count = COUNT_W'(stored.size());
    r.is_empty = (stored.size() == 0);
    return r;
  endfunction

  function automatic deque_result_t fixed(input logic [STATUS_W-1:0] status,
                                          input logic [VALUE_W-1:0] front_value,
                                          input logic [VALUE_W-1:0] back_value,
                                          input int count, input logic present);
    deque_result_t r;
    r.status = status;
    r.front_value = front_value;
    r.back_value = back_value;
    r.count = COUNT_W'(count);
    r.is_empty = (count == 0);
    r.was_present = present;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [MODE_W-1:0] mode,
                                    input logic [VALUE_W-1:0] value, input int reps,
                                    input bit typed, input deque_result_t want);
    stim_row_t s;
    s.mode = mode;
    s.value = value;
    s.reps = reps;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic offer(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value,
                       input bit typed, input deque_result_t want);
    deque_result_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= value;
    do @(posedge clk); while (!s_tready);
    predicted = deque_apply(mode, value);
    results_due.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  // mostly values from a small pool so duplicates, removes and full refusals happen
  task automatic random_item(output logic [MODE_W-1:0] mode, output logic [VALUE_W-1:0] value);
    int pick;
    int idx;
    pick = $urandom_range(99);
    if (pick < 22) mode = MODE_PUSH_FRONT;
    else if (pick < 44) mode = MODE_PUSH_BACK;
    else if (pick < 54) mode = MODE_POP_FRONT;
    else if (pick < 64) mode = MODE_POP_BACK;
    else if (pick < 78) mode = MODE_REMOVE;
    else if (pick < 92) mode = MODE_QUERY;
    else if (pick < 96) mode = MODE_SPARE;
    else mode = MODE_CLEAR;
    pick = $urandom_range(99);
    idx = $urandom_range(23);
    if (pick < 15 && stored.size() != 0) value = stored[$urandom_range(stored.size() - 1)];
    else if (pick < 80) begin
      case (idx)
        0: value = 32'h8000_0000;
        1: value = 32'h7fff_ffff;
        default: value = 32'(idx - 12);
      endcase
    end else value = $urandom;
  endtask

  task automatic compare_field(input string name, input logic [VALUE_W-1:0] want,
                               input logic [VALUE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat();
    deque_result_t want;
    deque_result_t got;
    got = m_tdata[72:0];
    if (results_due.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
      errors++;
    end else begin
      want = results_due.pop_front();
      compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
      compare_field("front_value", want.front_value, got.front_value);
      compare_field("back_value", want.back_value, got.back_value);
      compare_field("count", VALUE_W'(want.count), VALUE_W'(got.count));
      compare_field("is_empty", VALUE_W'(want.is_empty), VALUE_W'(got.is_empty));
      compare_field("was_present", VALUE_W'(want.was_present), VALUE_W'(got.was_present));
      compare_field("padding", '0, VALUE_W'(m_tdata[OUT_TDATA_W-1:73]));
    end
  endtask

  // receiver: checks beats and drives ready, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_beat();
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL unique_value_deque_top");
      $finish;
    end
  end

  initial begin
    logic [MODE_W-1:0] mode;
    logic [VALUE_W-1:0] value;
    deque_result_t none;
    none = '0;

    directed_rows.push_back(row(MODE_QUERY, 32'h0, 1, 1'b1,
                                fixed(ST_DONE, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_POP_FRONT, 32'h0, 1, 1'b1,
                                fixed(ST_MISS, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_POP_BACK, 32'h0, 1, 1'b1,
                                fixed(ST_MISS, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_REMOVE, 32'h1234, 1, 1'b1,
                                fixed(ST_MISS, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_CLEAR, 32'h0, 1, 1'b1,
                                fixed(ST_DONE, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_PUSH_BACK, 32'h8000_0000, 1, 1'b1,
                                fixed(ST_DONE, 32'h8000_0000, 32'h8000_0000, 1, 1'b0)));
    directed_rows.push_back(row(MODE_PUSH_FRONT, 32'h7fff_ffff, 1, 1'b1,
                                fixed(ST_DONE, 32'h7fff_ffff, 32'h8000_0000, 2, 1'b0)));
    directed_rows.push_back(row(MODE_PUSH_BACK, 32'h8000_0000, 1, 1'b1,
                                fixed(ST_DUP, 32'h7fff_ffff, 32'h8000_0000, 2, 1'b1)));
    directed_rows.push_back(row(MODE_PUSH_FRONT, 32'hffff_ffff, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_PUSH_BACK, 32'h0, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_QUERY, 32'h7fff_ffff, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_SPARE, 32'h0, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_REMOVE, 32'hffff_ffff, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_POP_FRONT, 32'h0, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_POP_BACK, 32'h0, 1, 1'b0, none));
    // fill to capacity, then refusals on a full deque
    directed_rows.push_back(row(MODE_PUSH_BACK, 32'h100, 15, 1'b0, none));
    directed_rows.push_back(row(MODE_PUSH_FRONT, 32'h5555_5555, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_PUSH_FRONT, 32'h8000_0000, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_REMOVE, 32'h107, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_REMOVE, 32'h10e, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_PUSH_FRONT, 32'haaaa_aaaa, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_QUERY, 32'haaaa_aaaa, 1, 1'b0, none));
    directed_rows.push_back(row(MODE_CLEAR, 32'h105, 1, 1'b1,
                                fixed(ST_DONE, 0, 0, 0, 1'b1)));
    directed_rows.push_back(row(MODE_POP_BACK, 32'h0, 1, 1'b1,
                                fixed(ST_MISS, 0, 0, 0, 1'b0)));
    directed_rows.push_back(row(MODE_CLEAR, 32'h0, 1, 1'b1,
                                fixed(ST_DONE, 0, 0, 0, 1'b0)));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      for (int r = 0; r < directed_rows[i].reps; r++)
        offer(directed_rows[i].mode, directed_rows[i].value + r,
              directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  hold_left = HOLD_CYCLES; end
        1: begin sender_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(mode, value);
        offer(mode, value, 1'b0, none);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS unique_value_deque_top");
    end else begin
      $display("FAIL unique_value_deque_top");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/uvd_pkg.sv
rtl/uvd_cell.sv
rtl/unique_value_deque_top.sv
bench/testbench.sv
